// File: sv/tun_pkg.sv
// tun_pkg: widths, payload types and helpers for the triangle unit normal block
// no dependencies; every other file of the block imports it

package tun_pkg;

  // field widths
  localparam int COORD_WIDTH  = 32;
  localparam int NORMAL_WIDTH = 16;

  // edge vectors, products and cross product components
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SHIFT_W = $clog2(CROSS_W);

  // scaled components lie in [-2^30, 2^30)
  localparam int M_W   = 31;
  localparam int SQ_W  = 2 * M_W - 1;
  localparam int SUM_W = SQ_W + 2;

  // square root
  localparam int ROOT_W       = 32;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int REM_W        = ROOT_W + 2;
  localparam int SQRT_STEPS   = 2;
  localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;

  // division
  localparam int QUO_W      = NORMAL_WIDTH;
  localparam int DVS_W      = ROOT_W + QUO_W + 1;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [DIFF_W-1:0]       diff_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [CROSS_W-1:0]      cross_comp_t;
  typedef logic signed [M_W-1:0]          mcomp_t;
  typedef logic signed [NORMAL_WIDTH-1:0] normal_t;

  typedef struct packed {
    coord_t a_x, a_y, a_z;
    coord_t b_x, b_y, b_z;
    coord_t c_x, c_y, c_z;
  } vtx_t;

  typedef struct packed {
    cross_comp_t n_x, n_y, n_z;
  } cross_t;

  typedef struct packed {
    mcomp_t m_x, m_y, m_z;
    logic   degen;
  } mvec_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    mvec_t            m;
  } sum_pkt_t;

  typedef struct packed {
    logic [ROOT_W-1:0] len;
    mvec_t             m;
  } root_pkt_t;

  typedef struct packed {
    normal_t n_x, n_y, n_z;
    logic    degenerate;
  } norm_t;

  // exact difference of two coordinates
  function automatic diff_t coord_sub(coord_t a, coord_t b);
    return diff_t'({a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b});
  endfunction

endpackage

// File: sv/tun_if.sv
// tun_if: valid/ready channels for vertex requests and normal results
// depends on tun_pkg

interface tun_in_if import tun_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t a_x, a_y, a_z;
  coord_t b_x, b_y, b_z;
  coord_t c_x, c_y, c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

interface tun_out_if import tun_pkg::*; ();
  logic    valid;
  logic    ready;
  normal_t n_x, n_y, n_z;
  logic    degenerate;

  modport source (
    output valid, n_x, n_y, n_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, n_x, n_y, n_z, degenerate,
    output ready
  );
endinterface

// File: sv/tun_cross.sv
// tun_cross: edge vectors and exact cross product, three register stages
// depends on tun_pkg

module tun_cross import tun_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  vtx_t   data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output cross_t data_o
);

  localparam int NS = 3;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  diff_t  ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  prod_t  p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  cross_t n_q;

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign data_o  = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // edge vectors u = a - b, v = b - c
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ux_q <= coord_sub(data_i.a_x, data_i.b_x);
      uy_q <= coord_sub(data_i.a_y, data_i.b_y);
      uz_q <= coord_sub(data_i.a_z, data_i.b_z);
      vx_q <= coord_sub(data_i.b_x, data_i.c_x);
      vy_q <= coord_sub(data_i.b_y, data_i.c_y);
      vz_q <= coord_sub(data_i.b_z, data_i.c_z);
    end
  end

  // six partial products
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p0_q <= uy_q * vz_q;
      p1_q <= uz_q * vy_q;
      p2_q <= uz_q * vx_q;
      p3_q <= ux_q * vz_q;
      p4_q <= ux_q * vy_q;
      p5_q <= uy_q * vx_q;
    end
  end

  // cross product components
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n_q.n_x <= CROSS_W'(p0_q) - CROSS_W'(p1_q);
      n_q.n_y <= CROSS_W'(p2_q) - CROSS_W'(p3_q);
      n_q.n_z <= CROSS_W'(p4_q) - CROSS_W'(p5_q);
    end
  end

endmodule

// File: sv/tun_norm.sv
// tun_norm: common right shift into 31 bits, squares and their sum
// depends on tun_pkg; four register stages

module tun_norm import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  cross_t   data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output sum_pkt_t data_o
);

  localparam int NS = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  cross_t             c_q;
  logic [SHIFT_W-1:0] sh_q, sh_d;
  logic               dg_q;
  mvec_t              m5_q, m6_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q, sqz_q;
  sum_pkt_t           out_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // shift search: highest bit that differs from its upper neighbor
  always_comb begin
    logic [CROSS_W-1:0] t;
    logic [SHIFT_W-1:0] h;
    t = (data_i.n_x ^ (data_i.n_x >>> 1)) |
        (data_i.n_y ^ (data_i.n_y >>> 1)) |
        (data_i.n_z ^ (data_i.n_z >>> 1));
    h = '0;
    for (int i = 0; i < CROSS_W; i++) begin
      if (t[i]) h = SHIFT_W'(i);
    end
    sh_d = (h > SHIFT_W'(M_W - 2)) ? h - SHIFT_W'(M_W - 2) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c_q  <= data_i;
      sh_q <= sh_d;
      dg_q <= ((data_i.n_x | data_i.n_y | data_i.n_z) == '0);
    end
  end

  // apply the shift
  always_ff @(posedge clk_i) begin
    logic signed [CROSS_W-1:0] sx, sy, sz;
    sx = c_q.n_x >>> sh_q;
    sy = c_q.n_y >>> sh_q;
    sz = c_q.n_z >>> sh_q;
    if (en[1]) begin
      m5_q.m_x   <= sx[M_W-1:0];
      m5_q.m_y   <= sy[M_W-1:0];
      m5_q.m_z   <= sz[M_W-1:0];
      m5_q.degen <= dg_q;
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    logic signed [2*M_W-1:0] px, py, pz;
    px = m5_q.m_x * m5_q.m_x;
    py = m5_q.m_y * m5_q.m_y;
    pz = m5_q.m_z * m5_q.m_z;
    if (en[2]) begin
      sqx_q <= px[SQ_W-1:0];
      sqy_q <= py[SQ_W-1:0];
      sqz_q <= pz[SQ_W-1:0];
      m6_q  <= m5_q;
    end
  end

  // sum of squares
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      out_q.sum <= SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
      out_q.m   <= m6_q;
    end
  end

endmodule

// File: sv/tun_sqrt.sv
// tun_sqrt: pipelined integer square root, two result bits per stage
// depends on tun_pkg

module tun_sqrt import tun_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  sum_pkt_t  data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output root_pkt_t data_o
);

  localparam int NS = SQRT_STAGES;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  logic [RAD_W-1:0]  rad_q  [NS];
  logic [REM_W-1:0]  rem_q  [NS];
  logic [ROOT_W-1:0] root_q [NS];
  mvec_t             pay_q  [NS];

  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o    = en[0];
  assign valid_o    = v_q[NS-1];
  assign data_o.len = root_q[NS-1];
  assign data_o.m   = pay_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RAD_W-1:0]  rad_in, rad_d;
    logic [REM_W-1:0]  rem_in, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    mvec_t             pay_in;

    if (s == 0) begin : g_first
      assign rad_in  = RAD_W'(data_i.sum);
      assign rem_in  = '0;
      assign root_in = '0;
      assign pay_in  = data_i.m;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign pay_in  = pay_q[s-1];
    end

    // bring in two radicand bits, try to set the next root bit
    always_comb begin
      logic [REM_W-1:0] rem2, trial;
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem2  = {rem_d[REM_W-3:0], rad_d[RAD_W-1 -: 2]};
        rad_d = rad_d << 2;
        trial = {root_d, 2'b01};
        if (rem2 >= trial) begin
          rem_d  = rem2 - trial;
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem2;
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rad_q[s]  <= rad_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        pay_q[s]  <= pay_in;
      end
    end
  end

endmodule

// File: sv/tun_div.sv
// tun_div: rounded division of each component by the length, then saturation
// depends on tun_pkg; restoring division, two quotient bits per stage

module tun_div import tun_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  root_pkt_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output norm_t     data_o
);

  localparam int DS = DIV_STAGES;
  localparam int NS = DS + 1;
  localparam logic [QUO_W-1:0] QOne = QUO_W'(1) << (QUO_W - 1);

  typedef struct packed {
    logic [2:0][DVS_W-1:0] rem;
    logic [2:0][QUO_W-1:0] quo;
    logic [ROOT_W:0]       dvs;
    logic [2:0]            neg;
    logic                  degen;
  } div_st_t;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  div_st_t st_q [DS];
  div_st_t st0;
  norm_t   out_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // dividend 2*|m|*2^(w-1) + len, divisor 2*len, for round half up
  always_comb begin
    logic [ROOT_W-1:0] len1;
    mcomp_t            mc [3];
    logic [M_W-1:0]    mag;
    len1  = (data_i.len == '0) ? ROOT_W'(1) : data_i.len;
    mc[0] = data_i.m.m_x;
    mc[1] = data_i.m.m_y;
    mc[2] = data_i.m.m_z;
    st0.dvs   = {len1, 1'b0};
    st0.degen = data_i.m.degen;
    st0.quo   = '0;
    for (int c = 0; c < 3; c++) begin
      mag = mc[c][M_W-1] ? M_W'(-mc[c]) : M_W'(mc[c]);
      st0.rem[c] = (DVS_W'(mag) << QUO_W) + DVS_W'(len1);
      st0.neg[c] = mc[c][M_W-1];
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_stage
    div_st_t st_in, st_d;

    if (s == 0) begin : g_first
      assign st_in = st0;
    end else begin : g_next
      assign st_in = st_q[s-1];
    end

    // subtract shifted divisor where it fits
    always_comb begin
      logic [DVS_W-1:0] dk;
      int               k;
      st_d = st_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        k = QUO_W - 1 - (s * DIV_STEPS + j);
        if (k >= 0) begin
          dk = DVS_W'(st_in.dvs) << k;
          for (int c = 0; c < 3; c++) begin
            if (st_d.rem[c] >= dk) begin
              st_d.rem[c] = st_d.rem[c] - dk;
              st_d.quo[c] = {st_d.quo[c][QUO_W-2:0], 1'b1};
            end else begin
              st_d.quo[c] = {st_d.quo[c][QUO_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) st_q[s] <= st_d;
    end
  end

  // saturate and apply the sign
  always_ff @(posedge clk_i) begin
    logic [QUO_W-1:0] q;
    normal_t          r [3];
    for (int c = 0; c < 3; c++) begin
      q = st_q[DS-1].quo[c];
      if (st_q[DS-1].neg[c]) begin
        if (q > QOne) q = QOne;
        r[c] = normal_t'(-q);
      end else begin
        if (q > QOne - 1'b1) q = QOne - 1'b1;
        r[c] = normal_t'(q);
      end
      if (st_q[DS-1].degen) r[c] = '0;
    end
    if (en[DS]) begin
      out_q.n_x        <= r[0];
      out_q.n_y        <= r[1];
      out_q.n_z        <= r[2];
      out_q.degenerate <= st_q[DS-1].degen;
    end
  end

endmodule

// File: sv/triangle_unit_normal.sv
// triangle_unit_normal: unit face normal of a triangle, fully pipelined
// depends on tun_pkg, tun_if, tun_cross, tun_norm, tun_sqrt, tun_div
//
// in_i carries one request: vertices a, b, c as signed Q16.16 coordinates.
// out_o returns one result per request: the unit normal of (a-b) x (b-c)
// in signed Q1.15, rounded to nearest, +1.0 saturated to 32767, and a
// degenerate flag with a zero normal when the cross product is zero.
// Both channels move an item when valid and ready are high at a clock edge.
// The pipeline computes the cross product, scaling and the sum of squares,
// the square root (two root bits per stage), the three dividers and the
// saturation register in turn. One request is taken every cycle unless a
// stall at out_o backs up the pipeline; the multipliers, root and divider
// stages are all pipelined, so nothing is shared between requests.
// Each stage holds a valid bit and advances when it is empty or when the
// stage after it advances, so a stall at out_o fills bubbles first and then
// holds every result in place; nothing is dropped or repeated.
// Reset clears all valid bits; the block is ready for requests as soon as
// reset is released and keeps no state between requests.

module triangle_unit_normal import tun_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tun_in_if.sink    in_i,
  tun_out_if.source out_o
);

  vtx_t      vtx;
  logic      c_valid, c_ready;
  cross_t    c_data;
  logic      n_valid, n_ready;
  sum_pkt_t  n_data;
  logic      r_valid, r_ready;
  root_pkt_t r_data;
  norm_t     res;

  // gather request fields
  assign vtx.a_x = in_i.a_x;
  assign vtx.a_y = in_i.a_y;
  assign vtx.a_z = in_i.a_z;
  assign vtx.b_x = in_i.b_x;
  assign vtx.b_y = in_i.b_y;
  assign vtx.b_z = in_i.b_z;
  assign vtx.c_x = in_i.c_x;
  assign vtx.c_y = in_i.c_y;
  assign vtx.c_z = in_i.c_z;

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (vtx),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .data_o  (c_data)
  );

  tun_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .data_i  (c_data),
    .valid_o (n_valid),
    .ready_i (n_ready),
    .data_o  (n_data)
  );

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid),
    .ready_o (n_ready),
    .data_i  (n_data),
    .valid_o (r_valid),
    .ready_i (r_ready),
    .data_o  (r_data)
  );

  tun_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (r_valid),
    .ready_o (r_ready),
    .data_i  (r_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  // result fields
  assign out_o.n_x        = res.n_x;
  assign out_o.n_y        = res.n_y;
  assign out_o.n_z        = res.n_z;
  assign out_o.degenerate = res.degenerate;

endmodule
